>>> sv/wheel_imu_dead_reckoning_macros.svh
// ----------------------------------------------------------------------------
// wheel_imu_dead_reckoning assertion macros
// shared assertion forms for the odometry block
// ----------------------------------------------------------------------------
`ifndef WHEEL_IMU_DEAD_RECKONING_MACROS_SVH
`define WHEEL_IMU_DEAD_RECKONING_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define WIDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define WIDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/widr_pkg.sv
// ----------------------------------------------------------------------------
// widr_pkg
// types and constants for the wheel/imu dead reckoning block
// ----------------------------------------------------------------------------
`default_nettype none
package widr_pkg;
  localparam int RadiusBits = 16;
  localparam int TrigBits   = 30;
  localparam int VecW       = 36;
  localparam int RotW       = 34;
  localparam logic signed [RotW-1:0] InvGain = 34'sd652032874;
  localparam logic signed [RotW-1:0] TrigOne = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] left_wheel_angle;
    logic signed [31:0] right_wheel_angle;
    logic signed [31:0] left_wheel_rate;
    logic signed [31:0] right_wheel_rate;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] forward_velocity;
  } out_item_t;

  typedef struct packed {
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [RotW-1:0] rx;
    logic signed [RotW-1:0] ry;
  } cordic_vec_t;
endpackage
`default_nettype wire

>>> sv/widr_if.sv
// ----------------------------------------------------------------------------
// widr_in_if / widr_out_if
// valid/ready channels of the dead reckoning block
// ----------------------------------------------------------------------------
`default_nettype none
interface widr_in_if;
  logic valid;
  logic ready;
  widr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface widr_out_if;
  logic valid;
  logic ready;
  widr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/wheel_imu_dead_reckoning.sv
// ----------------------------------------------------------------------------
// wheel_imu_dead_reckoning
// differential drive odometry with an imu heading
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. After acceptance, the wheel
// distances and heading vector are computed first, the heading then walks
// down a row of CORDIC_STEPS cordic cells (one per cycle), and then the cosine
// and sine are clamped, the projected steps formed and the accumulators
// saturated. One item is in flight at a time; the next is taken once the result
// register has been emptied. The radius register may be written only while the
// block is idle.
`default_nettype none
module wheel_imu_dead_reckoning #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  widr_in_if.sink          in_ch,
  widr_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import widr_pkg::*;

  localparam int Last = CORDIC_STEPS + 5;
  localparam int CntW = $clog2(Last + 1);

  // sequencer phases
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r;
  logic [15:0]     radius_r;
  logic            started_r;
  logic signed [31:0] pos_x_r, pos_y_r, prev_l_r, prev_r_r;

  in_item_t item_r;
  logic signed [47:0] ldist_p, rdist_p;
  logic signed [31:0] ldist_r, rdist_r;
  logic signed [32:0] rsum_r;
  logic signed [49:0] vel_p_r;
  logic signed [31:0] a_xy_r, a_wz_r, b_yy_r, b_zz_r;
  logic signed [34:0] a_r, b_r;
  logic signed [33:0] mean_r;
  logic               zero_r;
  logic [1:0]         quad_r;
  cordic_vec_t        seed, chain_out;
  logic signed [RotW-1:0] c_fix, s_fix, c_r, s_r;
  logic signed [67:0] px_p_r, py_p_r;
  out_item_t          res_r;

  logic acc_in, acc_out, en_chain;
  assign acc_in  = in_ch.valid && in_ch.ready;
  assign acc_out = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data = res_r;
  assign en_chain = (state_r == ST_BUSY);

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc_in) state_nxt = ST_BUSY;
      ST_BUSY: if (cnt_r == CntW'(Last)) state_nxt = ST_OUT;
      ST_OUT:  if (acc_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      radius_r <= 16'd2556;
    end else begin
      state_r <= state_nxt;
      if (acc_in) cnt_r <= '0;
      else if (en_chain) cnt_r <= cnt_r + 1'b1;
      if (cfg_we) radius_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) item_r <= in_ch.data;
  end

  // first step: products with the radius, wheel rate sum and quaternion products
  assign ldist_p = item_r.left_wheel_angle * $signed({1'b0, radius_r});
  assign rdist_p = item_r.right_wheel_angle * $signed({1'b0, radius_r});
  always_ff @(posedge clk) begin
    if (en_chain && cnt_r == '0) begin
      ldist_r <= 32'(ldist_p >>> RadiusBits);
      rdist_r <= 32'(rdist_p >>> RadiusBits);
      rsum_r  <= 33'(item_r.left_wheel_rate) + 33'(item_r.right_wheel_rate);
      a_xy_r  <= item_r.quat_x * item_r.quat_y;
      a_wz_r  <= item_r.quat_w * item_r.quat_z;
      b_yy_r  <= item_r.quat_y * item_r.quat_y;
      b_zz_r  <= item_r.quat_z * item_r.quat_z;
    end
  end

  // second step: heading vector, mean delta, velocity product
  logic signed [34:0] a_v, b_v;
  logic signed [31:0] pl_v, pr_v;
  assign a_v = (35'(a_xy_r) + 35'(a_wz_r)) <<< 1;
  assign b_v = 35'sd268435456 - ((35'(b_yy_r) + 35'(b_zz_r)) <<< 1);
  assign pl_v = started_r ? prev_l_r : ldist_r;
  assign pr_v = started_r ? prev_r_r : rdist_r;
  always_ff @(posedge clk) begin
    if (en_chain && cnt_r == CntW'(1)) begin
      a_r     <= a_v;
      b_r     <= b_v;
      zero_r  <= (a_v == 0) && (b_v == 0);
      mean_r  <= 34'((35'(ldist_r) - 35'(pl_v) + 35'(rdist_r) - 35'(pr_v)) >>> 1);
      vel_p_r <= rsum_r * $signed({1'b0, radius_r});
    end
  end

  // seed for the cell row, quadrant fold for b < 0
  always_comb begin
    seed.rx = InvGain;
    seed.ry = '0;
    quad_r  = 2'd0;
    seed.vx = VecW'(b_r);
    seed.vy = VecW'(a_r);
    if (b_r < 0) begin
      if (a_r >= 0) begin
        seed.vx = VecW'(a_r); seed.vy = -VecW'(b_r); quad_r = 2'd1;
      end else begin
        seed.vx = -VecW'(a_r); seed.vy = VecW'(b_r); quad_r = 2'd2;
      end
    end
  end

  logic [1:0] quad_hold_r;
  always_ff @(posedge clk) begin
    if (en_chain && cnt_r == CntW'(2)) quad_hold_r <= quad_r;
  end

  // cell row advances every busy cycle; result valid once the seed has passed all CORDIC_STEPS cells
  widr_cordic_chain #(.Steps(CORDIC_STEPS)) u_chain (
    .clk  (clk),
    .en   (en_chain),
    .d_in (seed),
    .d_out(chain_out)
  );

  // unfold and clamp to +-1.0
  always_comb begin
    c_fix = chain_out.rx;
    s_fix = chain_out.ry;
    if (quad_hold_r == 2'd1) begin
      c_fix = -chain_out.ry; s_fix = chain_out.rx;
    end else if (quad_hold_r == 2'd2) begin
      c_fix = chain_out.ry; s_fix = -chain_out.rx;
    end
    if (c_fix > TrigOne) c_fix = TrigOne;
    else if (c_fix < -TrigOne) c_fix = -TrigOne;
    if (s_fix > TrigOne) s_fix = TrigOne;
    else if (s_fix < -TrigOne) s_fix = -TrigOne;
    if (zero_r) begin
      c_fix = TrigOne; s_fix = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_chain && cnt_r == CntW'(CORDIC_STEPS + 2)) begin
      c_r <= c_fix;
      s_r <= s_fix;
    end
    if (en_chain && cnt_r == CntW'(CORDIC_STEPS + 3)) begin
      px_p_r <= mean_r * c_r;
      py_p_r <= mean_r * s_r;
    end
  end

  // final cycle: accumulate with saturation
  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) return 32'sh7fffffff;
    if (v < -70'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  logic signed [31:0] bx, by;
  assign bx = started_r ? pos_x_r : '0;
  assign by = started_r ? pos_y_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pos_x_r <= '0; pos_y_r <= '0; prev_l_r <= '0; prev_r_r <= '0;
    end else if (en_chain && cnt_r == CntW'(Last)) begin
      started_r <= 1'b1;
      pos_x_r  <= sat32(70'(bx) + 70'(px_p_r >>> TrigBits));
      pos_y_r  <= sat32(70'(by) + 70'(py_p_r >>> TrigBits));
      prev_l_r <= ldist_r;
      prev_r_r <= rdist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_chain && cnt_r == CntW'(Last)) begin
      res_r.pos_x <= sat32(70'(bx) + 70'(px_p_r >>> TrigBits));
      res_r.pos_y <= sat32(70'(by) + 70'(py_p_r >>> TrigBits));
      res_r.forward_velocity <= sat32(70'(vel_p_r >>> (RadiusBits + 1)));
    end
  end

  `include "wheel_imu_dead_reckoning_macros.svh"

  `WIDR_ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ch.ready, !out_ch.valid)
  `WIDR_ASSERT_NEXT(a_start_set, clk, rst_n, acc_out, started_r)
  `WIDR_ASSERT_IMPL(a_cnt_range, clk, rst_n, en_chain, cnt_r <= CntW'(Last))
endmodule
`default_nettype wire

>>> sv/widr_cordic_cell.sv
// ----------------------------------------------------------------------------
// widr_cordic_cell
// one cordic micro-rotation; holds its vector and, while enabled, hands it on each cycle
// ----------------------------------------------------------------------------
`default_nettype none
module widr_cordic_cell #(
  parameter int Shift = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire widr_pkg::cordic_vec_t d_in,
  output widr_pkg::cordic_vec_t     d_out
);
  import widr_pkg::*;
  cordic_vec_t q_r, q_nxt;

  always_comb begin
    if (d_in.vy >= 0) begin
      q_nxt.vx = d_in.vx + (d_in.vy >>> Shift);
      q_nxt.vy = d_in.vy - (d_in.vx >>> Shift);
      q_nxt.rx = d_in.rx - (d_in.ry >>> Shift);
      q_nxt.ry = d_in.ry + (d_in.rx >>> Shift);
    end else begin
      q_nxt.vx = d_in.vx - (d_in.vy >>> Shift);
      q_nxt.vy = d_in.vy + (d_in.vx >>> Shift);
      q_nxt.rx = d_in.rx + (d_in.ry >>> Shift);
      q_nxt.ry = d_in.ry - (d_in.rx >>> Shift);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule
`default_nettype wire

>>> sv/widr_cordic_chain.sv
// ----------------------------------------------------------------------------
// widr_cordic_chain
// row of cordic cells, one shift each, vectoring and rotation in lockstep
// ----------------------------------------------------------------------------
`default_nettype none
module widr_cordic_chain #(
  parameter int Steps = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire widr_pkg::cordic_vec_t d_in,
  output widr_pkg::cordic_vec_t      d_out
);
  import widr_pkg::*;
  cordic_vec_t link [Steps+1];

  assign link[0] = d_in;

  for (genvar i = 0; i < Steps; i++) begin : g_cell
    widr_cordic_cell #(.Shift(i)) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (link[i]),
      .d_out(link[i+1])
    );
  end

  assign d_out = link[Steps];
endmodule
`default_nettype wire
